// ----- hdl/cka_pkg.sv -----
// ----------------------------------------------------------------------------
// cka_pkg: shared types and constants of the category kappa agreement unit
// Field widths, register indexes, memory row layout and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cka_pkg;

  // Default values of the top level parameters.
  localparam int CATEGORIES_DEF   = 16;
  localparam int MAX_RATERS_DEF   = 32;
  localparam int MAX_SUBJECTS_DEF = 65536;

  // Port field widths.
  localparam int RATING_W   = 8;
  localparam int CAT_OUT_W  = 6;
  localparam int KAPPA_W    = 16;
  localparam int NUM_CAT_W  = 7;
  localparam int RATERS_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Stored count widths.
  localparam int SC_W      = 6;
  localparam int TC_W      = 32;
  localparam int PS_W      = 40;
  localparam int PS_HALF_W = 20;
  localparam int SS_W      = 24;

  // The quotient is taken with one extra fraction bit for rounding.
  localparam int ROUND_SH = 15;

  localparam logic [SC_W-1:0] SC_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CATEGORIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATERS         = 1'd1;

  localparam logic [NUM_CAT_W-1:0] NUM_CAT_RST = 7'd2;
  localparam logic [RATERS_W-1:0]  RATERS_RST  = 6'd2;

  localparam logic signed [KAPPA_W-1:0] KAPPA_POS_SAT = 16'sh7FFF;
  localparam logic signed [KAPPA_W-1:0] KAPPA_NEG_SAT = 16'sh8000;

  // One row of the count memory, one row per category.
  typedef struct packed {
    logic [SC_W-1:0] sc;
    logic [TC_W-1:0] tc;
    logic [PS_W-1:0] ps;
  } cka_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_take;
    logic cnt_wr;
    logic rd_cat;
    logic fold_wr;
    logic clr_wr;
    logic ss_inc;
    logic nr_ld;
    logic k_ld;
    logic m1;
    logic m2;
    logic m3;
    logic m4;
    logic m5;
    logic div_start;
    logic fmt;
    logic out_ld;
    logic cat_clr;
    logic cat_inc;
  } cka_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_end;
    logic data_end;
    logic cat_at_top;
    logic cat_at_k;
    logic undef_now;
    logic div_done;
    logic out_free;
  } cka_sts_t;

endpackage

// ----- hdl/cka_in_if.sv -----
// ----------------------------------------------------------------------------
// cka_in_if: rating input channel
// Valid/ready channel that carries one rating item with its subject and
// data set end flags.
// ----------------------------------------------------------------------------
interface cka_in_if import cka_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RATING_W-1:0] rating;
  logic                last_of_subject;
  logic                last_of_data;

  modport source (output valid, output rating, output last_of_subject,
                  output last_of_data, input ready);
  modport sink   (input valid, input rating, input last_of_subject,
                  input last_of_data, output ready);
endinterface

// ----- hdl/cka_out_if.sv -----
// ----------------------------------------------------------------------------
// cka_out_if: kappa result channel
// Valid/ready channel that carries one per-category kappa result item.
// ----------------------------------------------------------------------------
interface cka_out_if import cka_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CAT_OUT_W-1:0]       category;
  logic signed [KAPPA_W-1:0]  kappa;
  logic                       undefined;
  logic                       last_result;

  modport source (output valid, output category, output kappa, output undefined,
                  output last_result, input ready);
  modport sink   (input valid, input category, input kappa, input undefined,
                  input last_result, output ready);
endinterface

// ----- hdl/category_kappa_agreement_unit.sv -----
// ----------------------------------------------------------------------------
// category_kappa_agreement_unit: per-category Fleiss kappa accumulator
// Rating: a memory read-modify-write; a subject end adds a fold over all categories.
// Data end: each category's kappa via a 16-step divider, skipped if undefined,
// then a clear of all rows. Reset runs the same clear before any item.
// ----------------------------------------------------------------------------
module category_kappa_agreement_unit import cka_pkg::*; #(
  parameter int CATEGORIES   = CATEGORIES_DEF,
  parameter int MAX_RATERS   = MAX_RATERS_DEF,
  parameter int MAX_SUBJECTS = MAX_SUBJECTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cka_in_if.sink                in_item,
  cka_out_if.source             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cka_cmd_t cmd;
  cka_sts_t sts;
  logic     in_ready;

  // Sequencer.
  cka_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_item.ready = in_ready;

  // Counting memory, arithmetic and result register.
  cka_dp #(
    .CATEGORIES   (CATEGORIES),
    .MAX_RATERS   (MAX_RATERS),
    .MAX_SUBJECTS (MAX_SUBJECTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_rating          (in_item.rating),
    .in_last_of_subject (in_item.last_of_subject),
    .in_last_of_data    (in_item.last_of_data),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_item.valid),
    .out_ready          (out_item.ready),
    .out_category       (out_item.category),
    .out_kappa          (out_item.kappa),
    .out_undefined      (out_item.undefined),
    .out_last_result    (out_item.last_result)
  );

endmodule

// ----- hdl/cka_div.sv -----
// ----------------------------------------------------------------------------
// cka_div: radix-2 restoring divider for the kappa quotient
// Checks first whether the quotient overflows the result width, then
// produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cka_div import cka_pkg::*; #(
  parameter int NUM_W = 96,
  parameter int DVS_W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DVS_W-1:0]   dvs,
  output logic               done,
  output logic [KAPPA_W-1:0] q,
  output logic               ovf
);

  localparam int CNT_W = $clog2(KAPPA_W + 1);
  localparam int HI_W  = NUM_W - KAPPA_W;

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [DVS_W-1:0]   rem_r;
  logic [DVS_W-1:0]   rem_nxt;
  logic [KAPPA_W-1:0] low_r;
  logic [KAPPA_W-1:0] q_r;
  logic               ovf_r;
  logic [DVS_W:0]     trial;
  logic [DVS_W:0]     trial_sub;
  logic               trial_ge;
  logic [HI_W-1:0]    num_hi;
  logic               start_ovf;

  // Overflow when the numerator reaches the divisor shifted by the result width.
  assign num_hi    = num[NUM_W-1:KAPPA_W];
  assign start_ovf = num_hi >= HI_W'(dvs);

  // One restoring step: shift in the next numerator bit and try a subtract.
  assign trial     = {rem_r, low_r[KAPPA_W-1]};
  assign trial_ge  = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign rem_nxt   = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];

  // Control: busy flag, step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (start_ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(KAPPA_W);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands, partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= dvs;
      ovf_r <= start_ovf;
      q_r   <= '0;
      rem_r <= num[KAPPA_W+DVS_W-1:KAPPA_W];
      low_r <= num[KAPPA_W-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[KAPPA_W-2:0], 1'b0};
      q_r   <= {q_r[KAPPA_W-2:0], trial_ge};
    end
  end

  assign done = done_r;
  assign q    = q_r;
  assign ovf  = ovf_r;

endmodule

// ----- hdl/cka_ctrl.sv -----
// ----------------------------------------------------------------------------
// cka_ctrl: sequencer of the category kappa agreement unit
// Steps the datapath through rating counting, the subject fold over all
// categories, the per-category kappa evaluation and the clearing pass.
// ----------------------------------------------------------------------------
module cka_ctrl import cka_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cka_sts_t sts,
  output cka_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_FOLD_RD,
    ST_FOLD_WR,
    ST_NR,
    ST_K_RD,
    ST_K_LD,
    ST_K_M1,
    ST_K_M2,
    ST_K_M3,
    ST_K_M4,
    ST_K_M5,
    ST_K_DSTART,
    ST_K_DIV,
    ST_K_FMT,
    ST_K_PUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // State register; reset starts with the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cat_at_top) begin
          cmd.cat_clr = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.cat_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_nxt   = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = sts.item_end ? ST_FOLD_RD : ST_IDLE;
      end
      ST_FOLD_RD: begin
        cmd.rd_cat = 1'b1;
        state_nxt  = ST_FOLD_WR;
      end
      ST_FOLD_WR: begin
        cmd.fold_wr = 1'b1;
        if (sts.cat_at_top) begin
          cmd.cat_clr = 1'b1;
          cmd.ss_inc  = 1'b1;
          state_nxt   = sts.data_end ? ST_NR : ST_IDLE;
        end else begin
          cmd.cat_inc = 1'b1;
          state_nxt   = ST_FOLD_RD;
        end
      end
      ST_NR: begin
        cmd.nr_ld = 1'b1;
        state_nxt = ST_K_RD;
      end
      ST_K_RD: begin
        cmd.rd_cat = 1'b1;
        state_nxt  = ST_K_LD;
      end
      ST_K_LD: begin
        cmd.k_ld  = 1'b1;
        state_nxt = sts.undef_now ? ST_K_PUT : ST_K_M1;
      end
      ST_K_M1: begin
        cmd.m1    = 1'b1;
        state_nxt = ST_K_M2;
      end
      ST_K_M2: begin
        cmd.m2    = 1'b1;
        state_nxt = ST_K_M3;
      end
      ST_K_M3: begin
        cmd.m3    = 1'b1;
        state_nxt = ST_K_M4;
      end
      ST_K_M4: begin
        cmd.m4    = 1'b1;
        state_nxt = ST_K_M5;
      end
      ST_K_M5: begin
        cmd.m5    = 1'b1;
        state_nxt = ST_K_DSTART;
      end
      ST_K_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_K_DIV;
      end
      ST_K_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_K_FMT;
        end
      end
      ST_K_FMT: begin
        cmd.fmt   = 1'b1;
        state_nxt = ST_K_PUT;
      end
      ST_K_PUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          if (sts.cat_at_k) begin
            cmd.cat_clr = 1'b1;
            state_nxt   = ST_CLEAR;
          end else begin
            cmd.cat_inc = 1'b1;
            state_nxt   = ST_K_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/cka_dp.sv -----
// ----------------------------------------------------------------------------
// cka_dp: datapath of the category kappa agreement unit
// Configuration registers, the per-category count memory, the subject
// counter, the kappa arithmetic stages, the divider and the result register.
// ----------------------------------------------------------------------------
module cka_dp import cka_pkg::*; #(
  parameter int CATEGORIES   = CATEGORIES_DEF,
  parameter int MAX_RATERS   = MAX_RATERS_DEF,
  parameter int MAX_SUBJECTS = MAX_SUBJECTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [RATING_W-1:0]       in_rating,
  input  logic                      in_last_of_subject,
  input  logic                      in_last_of_data,
  input  cka_cmd_t                  cmd,
  output cka_sts_t                  sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CAT_OUT_W-1:0]      out_category,
  output logic signed [KAPPA_W-1:0] out_kappa,
  output logic                      out_undefined,
  output logic                      out_last_result
);

  localparam int AW     = $clog2(CATEGORIES);
  localparam int RM_W   = $clog2(MAX_RATERS);
  localparam int NR_W   = $clog2(MAX_SUBJECTS * MAX_RATERS + 1);
  localparam int NRP_W  = SS_W + RATERS_W;
  localparam int PI_W   = 2 * SC_W;
  localparam int PA_W   = PS_HALF_W + NR_W;
  localparam int A_W    = PS_W + NR_W;
  localparam int D_W    = A_W + 1;
  localparam int TT_W   = 2 * NR_W;
  localparam int B_W    = TT_W + RM_W;
  localparam int DEN_W  = TT_W + RM_W;
  localparam int NUM_W  = A_W + ROUND_SH + 1;
  localparam int DVS_W  = DEN_W + 1;

  localparam logic [NUM_CAT_W-1:0] K_MAX  = NUM_CAT_W'(CATEGORIES);
  localparam logic [RATERS_W-1:0]  R_MIN  = RATERS_W'(2);
  localparam logic [RATERS_W-1:0]  R_MAX  = RATERS_W'(MAX_RATERS);
  localparam logic [AW-1:0]        CAT_TOP = AW'(CATEGORIES - 1);
  localparam logic [SS_W-1:0]      SS_LIM = SS_W'(MAX_SUBJECTS);

  // Configuration and effective (clamped) values.
  logic [NUM_CAT_W-1:0] num_cat_r;
  logic [RATERS_W-1:0]  raters_r;
  logic [NUM_CAT_W-1:0] k_eff;
  logic [NUM_CAT_W-1:0] k_m1;
  logic [RATERS_W-1:0]  r_eff;
  logic [RATERS_W-1:0]  r_m1_full;
  logic [RM_W-1:0]      rm1;

  // Item, memory and walk state.
  logic [RATING_W-1:0]  item_rating_r;
  logic                 end_subj_r;
  logic                 end_data_r;
  logic                 rating_ok;
  cka_row_t             mem_r [CATEGORIES];
  cka_row_t             rd_row_r;
  logic [AW-1:0]        rd_addr;
  logic                 rd_en;
  logic                 mem_we;
  logic [AW-1:0]        wr_addr;
  cka_row_t             wr_row;
  logic [AW-1:0]        cat_r;
  logic [SS_W-1:0]      ss_r;
  logic                 fold_en;
  logic [SC_W-1:0]      n_m1;
  logic [PI_W-1:0]      pair_inc;

  // Kappa arithmetic.
  logic [NRP_W-1:0]     nr_full;
  logic [NR_W-1:0]      nr_r;
  logic [NR_W-1:0]      t_r;
  logic [PS_W-1:0]      s_r;
  logic                 undef_r;
  logic [PA_W-1:0]      pa_lo_r;
  logic [PA_W-1:0]      pa_hi_r;
  logic [TT_W-1:0]      tt_r;
  logic [NR_W-1:0]      nmt_r;
  logic [A_W-1:0]       a_r;
  logic [B_W-1:0]       b_r;
  logic [TT_W-1:0]      tn_r;
  logic [D_W-1:0]       diff_r;
  logic [D_W-1:0]       diff_neg;
  logic [DEN_W-1:0]     den_r;
  logic                 neg_r;
  logic [A_W-1:0]       mag_r;
  logic [NUM_W-1:0]     num_r;
  logic [DVS_W-1:0]     dvs;
  logic                 div_done;
  logic [KAPPA_W-1:0]   div_q;
  logic                 div_ovf;
  logic                 q_sat;
  logic signed [KAPPA_W-1:0] kappa_r;
  logic signed [KAPPA_W-1:0] kappa_nxt;

  // Result register.
  logic                      out_valid_r;
  logic [CAT_OUT_W-1:0]      out_cat_r;
  logic signed [KAPPA_W-1:0] out_kappa_r;
  logic                      out_undef_r;
  logic                      out_last_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cat_r <= NUM_CAT_RST;
      raters_r  <= RATERS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_CATEGORIES: num_cat_r <= cfg_wdata;
        CFG_RATERS:         raters_r  <= cfg_wdata[RATERS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the category count to 1..CATEGORIES and the rater count to 2..MAX_RATERS.
  always_comb begin
    if (num_cat_r == '0) begin
      k_eff = NUM_CAT_W'(1);
    end else if (num_cat_r > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = num_cat_r;
    end
    if (raters_r < R_MIN) begin
      r_eff = R_MIN;
    end else if (raters_r > R_MAX) begin
      r_eff = R_MAX;
    end else begin
      r_eff = raters_r;
    end
  end

  assign k_m1      = k_eff - NUM_CAT_W'(1);
  assign r_m1_full = r_eff - RATERS_W'(1);
  assign rm1       = r_m1_full[RM_W-1:0];

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      item_rating_r <= in_rating;
      end_subj_r    <= in_last_of_subject;
      end_data_r    <= in_last_of_data;
    end
  end

  assign rating_ok = item_rating_r < RATING_W'(k_eff);

  // Category walk counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_r <= '0;
    end else if (cmd.cat_clr) begin
      cat_r <= '0;
    end else if (cmd.cat_inc) begin
      cat_r <= cat_r + AW'(1);
    end
  end

  // Subject counter: stops at the limit, cleared by the clearing pass.
  assign fold_en = ss_r < SS_LIM;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_r <= '0;
    end else if (cmd.clr_wr) begin
      ss_r <= '0;
    end else if (cmd.ss_inc && fold_en) begin
      ss_r <= ss_r + SS_W'(1);
    end
  end

  // Memory read port: the rating's row on item accept, else the walk row.
  assign rd_en   = cmd.in_take | cmd.rd_cat;
  assign rd_addr = cmd.in_take ? in_rating[AW-1:0] : cat_r;

  // The pair term n(n-1) of one subject; zero when n is zero.
  assign n_m1     = rd_row_r.sc - SC_W'(1);
  assign pair_inc = PI_W'(rd_row_r.sc) * PI_W'(n_m1);

  // Memory write port: count increment, subject fold or clear.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cat_r;
    wr_row  = rd_row_r;
    if (cmd.cnt_wr) begin
      mem_we    = rating_ok && (rd_row_r.sc != SC_MAX);
      wr_addr   = item_rating_r[AW-1:0];
      wr_row.sc = rd_row_r.sc + SC_W'(1);
    end else if (cmd.fold_wr) begin
      mem_we    = 1'b1;
      wr_row.sc = '0;
      if (fold_en) begin
        wr_row.tc = rd_row_r.tc + TC_W'(rd_row_r.sc);
        wr_row.ps = rd_row_r.ps + PS_W'(pair_inc);
      end
    end else if (cmd.clr_wr) begin
      mem_we = 1'b1;
      wr_row = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem_r[rd_addr];
    end
  end

  // Rated items in total: N*R.
  assign nr_full = NRP_W'(ss_r) * NRP_W'(r_eff);

  // A category is undefined when its total is zero or reaches N*R.
  assign sts.undef_now = (rd_row_r.tc == '0) || (rd_row_r.tc >= TC_W'(nr_r));

  // Kappa stages: numerator S*N*R-(R-1)T^2, denominator (R-1)T(NR-T).
  assign diff_neg = '0 - diff_r;

  always_ff @(posedge clk) begin
    if (cmd.nr_ld) begin
      nr_r <= nr_full[NR_W-1:0];
    end
    if (cmd.k_ld) begin
      t_r     <= rd_row_r.tc[NR_W-1:0];
      s_r     <= rd_row_r.ps;
      undef_r <= sts.undef_now;
    end
    if (cmd.m1) begin
      pa_lo_r <= PA_W'(s_r[PS_HALF_W-1:0]) * PA_W'(nr_r);
      pa_hi_r <= PA_W'(s_r[PS_W-1:PS_HALF_W]) * PA_W'(nr_r);
      tt_r    <= TT_W'(t_r) * TT_W'(t_r);
      nmt_r   <= nr_r - t_r;
    end
    if (cmd.m2) begin
      a_r  <= A_W'(pa_lo_r) + (A_W'(pa_hi_r) << PS_HALF_W);
      b_r  <= B_W'(tt_r) * B_W'(rm1);
      tn_r <= TT_W'(t_r) * TT_W'(nmt_r);
    end
    if (cmd.m3) begin
      diff_r <= {1'b0, a_r} - D_W'(b_r);
      den_r  <= DEN_W'(tn_r) * DEN_W'(rm1);
    end
    if (cmd.m4) begin
      neg_r <= diff_r[A_W];
      mag_r <= diff_r[A_W] ? diff_neg[A_W-1:0] : diff_r[A_W-1:0];
    end
    if (cmd.m5) begin
      num_r <= (NUM_W'(mag_r) << ROUND_SH) + NUM_W'(den_r);
    end
    if (cmd.fmt) begin
      kappa_r <= kappa_nxt;
    end
  end

  // Round half away from zero: (2*mag*2^14 + den) / (2*den).
  assign dvs = DVS_W'(den_r) << 1;

  cka_div #(
    .NUM_W (NUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .dvs   (dvs),
    .done  (div_done),
    .q     (div_q),
    .ovf   (div_ovf)
  );

  // Apply the sign and saturate to the Q2.14 range.
  assign q_sat = div_ovf | div_q[KAPPA_W-1];

  always_comb begin
    if (!neg_r) begin
      kappa_nxt = q_sat ? KAPPA_POS_SAT : KAPPA_W'(div_q);
    end else begin
      kappa_nxt = q_sat ? KAPPA_NEG_SAT : KAPPA_W'('0 - div_q);
    end
  end

  // Result register; loads when empty or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_cat_r   <= CAT_OUT_W'(cat_r);
      out_kappa_r <= undef_r ? '0 : kappa_r;
      out_undef_r <= undef_r;
      out_last_r  <= sts.cat_at_k;
    end
  end

  // Status toward the controller.
  assign sts.item_end   = end_subj_r | end_data_r;
  assign sts.data_end   = end_data_r;
  assign sts.cat_at_top = cat_r == CAT_TOP;
  assign sts.cat_at_k   = NUM_CAT_W'(cat_r) == k_m1;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_category    = out_cat_r;
  assign out_kappa       = out_kappa_r;
  assign out_undefined   = out_undef_r;
  assign out_last_result = out_last_r;

endmodule
